// ----- rtl/pcrp_pkg.sv -----
// ----------------------------------------------------------------------------
// pcrp_pkg: shared types and constants for the PC reuse predictor table
// Kind codes, hash constants, step counts and controller/datapath interface.
// ----------------------------------------------------------------------------
package pcrp_pkg;

  localparam int TABLE_ENTRIES_DEF = 2048;
  localparam int COUNTER_MAX_DEF   = 7;

  localparam int KIND_W = 2;
  localparam int PC_W   = 64;

  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEC   = 2'd2;

  localparam logic [31:0] HASH_POLY      = 32'hEDB88320;
  localparam int          HASH_ROUNDS    = 32;
  localparam int          HASH_PER_CYCLE = 8;
  localparam int          HASH_CYCLES    = HASH_ROUNDS / HASH_PER_CYCLE;
  // hash result fits in HASH_ROUNDS bits after that many right shifts
  localparam int          HASH_W         = HASH_ROUNDS;
  // reciprocal multiply, quotient times size, subtract and correct
  localparam int          MOD_CYCLES     = 3;
  localparam int          STEP_W         = $clog2(HASH_CYCLES + MOD_CYCLES);

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic hash_step;
    logic mod_step;
    logic mem_rd;
    logic update;
  } pcrp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hash_last;
    logic mod_last;
  } pcrp_status_t;

endpackage

// ----- rtl/pcrp_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcrp_ctrl: sequencer for the PC reuse predictor table
// Runs the post-reset clearing pass, then steps each request through hash,
// modulo reduction, table read and counter update.
// ----------------------------------------------------------------------------
module pcrp_ctrl
  import pcrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  pcrp_status_t status,
  output pcrp_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HASH  = 6'b000100,
    ST_MOD   = 6'b001000,
    ST_READ  = 6'b010000,
    ST_UPD   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start) state_nxt = ST_HASH;
      end
      ST_HASH: begin
        cmd.hash_step = 1'b1;
        if (status.hash_last) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/pcrp_dp.sv -----
// ----------------------------------------------------------------------------
// pcrp_dp: datapath of the PC reuse predictor table
// Iterative PC hash, modulo reduction by reciprocal multiplication, counter
// memory and saturating update, plus the registered result.
// ----------------------------------------------------------------------------
module pcrp_dp
  import pcrp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COUNTER_MAX   = COUNTER_MAX_DEF
)(
  input  logic              clk,
  input  logic              rst_n,
  input  pcrp_cmd_t         cmd,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [PC_W-1:0]   in_pc,
  output pcrp_status_t      status,
  output logic              out_valid,
  output logic              out_friendly
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(COUNTER_MAX + 1);
  localparam logic [HASH_W-1:0] MOD_N    = HASH_W'(TABLE_ENTRIES);
  // floor(2^HASH_W / N): quotient estimate is exact or one short
  localparam logic [HASH_W-1:0] RECIP    =
    HASH_W'((64'd1 << HASH_W) / 64'(TABLE_ENTRIES));
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] CMAX     = CW'(COUNTER_MAX);
  localparam logic [CW-1:0] MID      = CW'((COUNTER_MAX + 1) / 2);
  localparam logic [STEP_W-1:0] HASH_LAST = STEP_W'(HASH_CYCLES - 1);
  localparam logic [STEP_W-1:0] MOD_MUL   = STEP_W'(HASH_CYCLES);
  localparam logic [STEP_W-1:0] MOD_QN    = STEP_W'(HASH_CYCLES + 1);
  localparam logic [STEP_W-1:0] MOD_LAST  = STEP_W'(HASH_CYCLES + MOD_CYCLES - 1);

  function automatic logic [PC_W-1:0] hash_rounds(input logic [PC_W-1:0] v);
    logic [PC_W-1:0] x;
    x = v;
    for (int r = 0; r < HASH_PER_CYCLE; r++) begin
      x = x[0] ? ((x >> 1) ^ {{(PC_W-32){1'b0}}, HASH_POLY}) : (x >> 1);
    end
    return x;
  endfunction

  logic [PC_W-1:0]   hash_r;
  logic [HASH_W-1:0] quot_r;
  logic [HASH_W-1:0] qn_r;
  logic [IW-1:0]     rem_r;
  logic [KIND_W-1:0] kind_r;
  logic [STEP_W-1:0] step_r;
  logic [IW-1:0]     clr_r;
  logic [CW-1:0]     rd_data_r;
  logic              out_valid_r;
  logic              out_friendly_r;

  logic [CW-1:0]     mem [TABLE_ENTRIES];

  logic [2*HASH_W-1:0] mod_prod;
  logic [HASH_W-1:0]   mod_diff;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [CW-1:0]     wdata;
  logic [CW-1:0]     cnt_nxt;
  logic              is_train;

  assign mod_prod = (2*HASH_W)'(hash_r[HASH_W-1:0]) * (2*HASH_W)'(RECIP);
  assign mod_diff = hash_r[HASH_W-1:0] - qn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        step_r <= '0;
      end else if (cmd.hash_step || cmd.mod_step) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (cmd.clear_wr) clr_r <= clr_r + IW'(1);
      out_valid_r <= cmd.update && (kind_r == KIND_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hash_r <= in_pc;
      kind_r <= in_kind;
      rem_r  <= '0;
    end else if (cmd.hash_step) begin
      hash_r <= hash_rounds(hash_r);
    end else if (cmd.mod_step) begin
      if (step_r == MOD_MUL) begin
        quot_r <= mod_prod[2*HASH_W-1:HASH_W];
      end else if (step_r == MOD_QN) begin
        qn_r <= quot_r * MOD_N;
      end else begin
        rem_r <= (mod_diff >= MOD_N) ? IW'(mod_diff - MOD_N) : IW'(mod_diff);
      end
    end
    if (cmd.update) out_friendly_r <= (rd_data_r >= MID);
  end

  always_comb begin
    is_train = 1'b0;
    cnt_nxt  = rd_data_r;
    unique case (kind_r)
      KIND_INC: begin
        is_train = 1'b1;
        cnt_nxt  = (rd_data_r == CMAX) ? rd_data_r : rd_data_r + CW'(1);
      end
      KIND_DEC: begin
        is_train = 1'b1;
        cnt_nxt  = (rd_data_r == '0) ? rd_data_r : rd_data_r - CW'(1);
      end
      default: begin
        is_train = 1'b0;
      end
    endcase
  end

  assign we    = cmd.clear_wr || (cmd.update && is_train);
  assign waddr = cmd.clear_wr ? clr_r : rem_r;
  assign wdata = cmd.clear_wr ? MID : cnt_nxt;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_data_r <= mem[rem_r];
  end

  assign status.clear_last = (clr_r == LAST_IDX);
  assign status.hash_last  = (step_r == HASH_LAST);
  assign status.mod_last   = (step_r == MOD_LAST);

  assign out_valid    = out_valid_r;
  assign out_friendly = out_friendly_r;

endmodule

// ----- rtl/pc_reuse_predictor_table.sv -----
// ----------------------------------------------------------------------------
// pc_reuse_predictor_table: PC-signature reuse predictor
// Hashes a program counter to a slot of saturating counters; queries return
// a friendly bit, training requests move the counter up or down.
// ----------------------------------------------------------------------------
// After reset the block sweeps the counter memory to the midpoint, one entry
// per cycle, holding busy high until the sweep ends. A request is taken when
// start is high and busy is low; busy then stays high through the repeated
// steps of the shared 8-round hash, the modulo reduction by reciprocal
// multiplication, the memory read and the update. A query's result appears
// with out_valid for one cycle, in the cycle in which busy is low again, and
// no new request is taken while one is in work. Training requests and kind 3
// give no result. Results cannot be held off by the receiver.
module pc_reuse_predictor_table
  import pcrp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COUNTER_MAX   = COUNTER_MAX_DEF
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [PC_W-1:0]   in_pc,
  output logic              out_valid,
  output logic              out_friendly
);

  pcrp_cmd_t    cmd;
  pcrp_status_t status;

  pcrp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pcrp_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNTER_MAX   (COUNTER_MAX)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_kind      (in_kind),
    .in_pc        (in_pc),
    .status       (status),
    .out_valid    (out_valid),
    .out_friendly (out_friendly)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");
`endif

endmodule

// ----- sim/pc_reuse_predictor_table_tb.sv -----
// ----------------------------------------------------------------------------
// pc_reuse_predictor_table_tb: request-level test of the PC reuse predictor
// Drives query, training and unused-kind requests through the start/busy handshake,
// mostly with random gaps, and checks every friendly bit against an in-bench model of the
// hashed saturating-counter table. Most random requests reuse a small pool
// of PCs so that counters climb and fall to their limits.
// ----------------------------------------------------------------------------
module pc_reuse_predictor_table_tb;
  import pcrp_pkg::*;

  localparam int          TBL_SIZE    = 2048;
  localparam int          CTR_MAX     = 7;
  localparam int          CTR_MID     = (CTR_MAX + 1) / 2;
  localparam logic [63:0] CRC_POLY    = 64'h0000_0000_EDB8_8320;
  localparam int          CRC_ROUNDS  = 32;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int          N_RANDOM    = 1500;
  localparam int          N_PHASES    = 6;
  localparam int          POOL_SIZE   = 8;

  class friendly_predictor;
    logic [7:0] ctr_table[TBL_SIZE];
    logic       friendly_due[$];
    int         mismatches;
    int         checked;
    int         sat_hits;
    int         kind_seen[4];

    function new();
      foreach (ctr_table[i]) ctr_table[i] = 8'(CTR_MID);
    endfunction

    function int slot_of(logic [63:0] pc);
      logic [63:0] h;
      h = pc;
      for (int r = 0; r < CRC_ROUNDS; r++)
        h = h[0] ? ((h >> 1) ^ CRC_POLY) : (h >> 1);
      return int'(h % TBL_SIZE);
    endfunction

    function void take_request(logic [KIND_W-1:0] kind, logic [63:0] pc);
      int s;
      s = slot_of(pc);
      kind_seen[kind]++;
      case (kind)
        KIND_QUERY: friendly_due.push_back(ctr_table[s] >= CTR_MID);
        KIND_INC: begin
          if (ctr_table[s] < CTR_MAX) ctr_table[s]++;
          else sat_hits++;
        end
        KIND_DEC: begin
          if (ctr_table[s] != 0) ctr_table[s]--;
          else sat_hits++;
        end
        default: ;
      endcase
    endfunction

    function void check_friendly(logic got);
      logic want;
      checked++;
      if (friendly_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no query pending, out_friendly=%b", $time, got);
      end else begin
        want = friendly_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: out_friendly expected %b got %b", $time, want, got);
        end
      end
    endfunction

    function void flush_check();
      if (friendly_due.size() > 0) begin
        mismatches += friendly_due.size();
        $display("%0d query results never arrived", friendly_due.size());
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [KIND_W-1:0] in_kind = KIND_QUERY;
  logic [PC_W-1:0]   in_pc = '0;
  logic              busy;
  logic              out_valid;
  logic              out_friendly;

  friendly_predictor pred = new();

  pc_reuse_predictor_table dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_pc        (in_pc),
    .out_valid    (out_valid),
    .out_friendly (out_friendly)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) pred.check_friendly(out_friendly);
  end

  task automatic send_request(logic [KIND_W-1:0] k, logic [63:0] p);
    start   <= 1'b1;
    in_kind <= k;
    in_pc   <= p;
    do @(posedge clk); while (busy !== 1'b0);
    pred.take_request(k, p);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pred.friendly_due.size() > 0) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // bias 0: mostly up, 1: mostly down, else balanced
  function automatic logic [KIND_W-1:0] pick_kind(int bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return KIND_UNUSED;
    if (r < 40) return KIND_QUERY;
    case (bias)
      0:       return (r < 85) ? KIND_INC : KIND_DEC;
      1:       return (r < 55) ? KIND_INC : KIND_DEC;
      default: return (r < 70) ? KIND_INC : KIND_DEC;
    endcase
  endfunction

  initial begin
    logic [63:0]       pool[POOL_SIZE];
    logic [63:0]       pa;
    logic [63:0]       pb;
    logic [63:0]       p;
    logic [KIND_W-1:0] k;
    bit                quiet;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pa = 64'h0000_7f3a_0040_1a30;
    pb = '1;
    send_request(KIND_QUERY, '0);
    send_request(KIND_QUERY, pb);
    send_request(KIND_UNUSED, '0);
    send_request(KIND_QUERY, '0);
    repeat (4) send_request(KIND_INC, pa);   // last one saturates
    send_request(KIND_QUERY, pa);
    pause(3);
    repeat (8) send_request(KIND_DEC, pa);   // bottoms out at zero
    send_request(KIND_QUERY, pa);
    send_request(KIND_DEC, pb);
    send_request(KIND_QUERY, pb);
    send_request(KIND_UNUSED, pb);
    send_request(KIND_QUERY, pb);
    pause(7);
    send_request(KIND_INC, pb);
    send_request(KIND_QUERY, pb);
    wait_drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      quiet = (ph == 4);
      foreach (pool[i]) pool[i] = {$urandom, $urandom};
      for (int i = 0; i < N_RANDOM / N_PHASES; i++) begin
        k = pick_kind(ph % 3);
        if ($urandom_range(0, 4) == 0) p = {$urandom, $urandom};
        else p = pool[$urandom_range(0, POOL_SIZE - 1)];
        send_request(k, p);
        pause(quiet ? 0 : pick_gap());
      end
      wait_drain();
    end

    start <= 1'b0;
    for (int i = 0; i < 500 && pred.friendly_due.size() > 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    pred.flush_check();

    $display("covered %0d queries, %0d up and %0d down trainings, %0d unused-kind requests",
             pred.kind_seen[0], pred.kind_seen[1], pred.kind_seen[2], pred.kind_seen[3]);
    $display("%0d friendly bits checked, %0d trainings hit a counter limit",
             pred.checked, pred.sat_hits);
    if (pred.mismatches == 0) begin
      $display("pc_reuse_predictor_table_tb: done, clean");
    end else begin
      $display("%0d mismatches", pred.mismatches);
      $display("pc_reuse_predictor_table_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("pc_reuse_predictor_table_tb: done, errors");
    $finish;
  end

endmodule
